@@ src/plob_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package plob_pkg;
   localparam int DEPTH_DEFAULT = 64;
   localparam int MAX_ROWS = 64;
   localparam int VAL_W = 31;

   localparam logic [1:0] FUNC_ADD_BID = 2'd0;
   localparam logic [1:0] FUNC_ADD_ASK = 2'd1;
   localparam logic [1:0] FUNC_AGGREGATE = 2'd2;
   localparam logic [1:0] FUNC_DUMP = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [VAL_W-1:0] price;
      logic [VAL_W-1:0] qty;
   } entry_type;
endpackage
`default_nettype wire

@@ src/plob_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface plob_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] price;
   logic signed [31:0] quantity;
   modport source (output valid, func, price, quantity, input ready);
   modport sink (input valid, func, price, quantity, output ready);
endinterface

interface plob_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [30:0] bid_price;
   logic [30:0] bid_qty;
   logic        bid_valid;
   logic [30:0] ask_price;
   logic [30:0] ask_qty;
   logic        ask_valid;
   logic        last;
   modport source (output valid, status, bid_price, bid_qty, bid_valid, ask_price, ask_qty,
                   ask_valid, last, input ready);
   modport sink (input valid, status, bid_price, bid_qty, bid_valid, ask_price, ask_qty,
                 ask_valid, last, output ready);
endinterface
`default_nettype wire

@@ src/plob_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module plob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ src/price_level_order_book.sv @@
// Two-sided price-level order book (bids best-first descending, asks ascending).
// req_chan: one beat per command (func, price, quantity), valid/ready.
// rsp_chan: result beats, valid/ready; every command except an empty dump
//   gives at least one beat, and the final beat of a command has last set.
// Add: the insert walks from the tail toward the head, shifting each entry
//   that sits behind the new one down one place, one read/write pair per
//   entry through the side's RAM; invalid or full adds go straight to
//   the single response beat.
// Aggregate: a read/write pair per stored entry, bid side then ask side.
// Dump: each row is a RAM read, then a load of the output register.
// One command is worked at a time; req_ready is high only while idle.
// The output register holds a beat until taken, so a stalled receiver
// stalls the walk; no beat is lost or repeated.
// Reset (synchronous, active high) empties both sides by clearing the
// counts; the entry RAMs need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module price_level_order_book #(
   parameter int DEPTH = plob_pkg::DEPTH_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   plob_req_if.sink   req_chan,
   plob_rsp_if.source rsp_chan
);
   import plob_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADD_RD = 3'd1;
   localparam logic [2:0] S_ADD_WR = 3'd2;
   localparam logic [2:0] S_AGG_RD = 3'd3;
   localparam logic [2:0] S_AGG_WR = 3'd4;
   localparam logic [2:0] S_DMP_RD = 3'd5;
   localparam logic [2:0] S_DMP_WR = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    bid_cnt_ff, bid_cnt_in, ask_cnt_ff, ask_cnt_in;
   logic [CW-1:0]    idx_ff, idx_in, wptr_ff, wptr_in, rows_ff, rows_in;
   logic             side_ff, side_in;
   entry_type        new_ff, new_in, last_ff, last_in;
   logic [1:0]       status_ff, status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       o_status_ff, o_status_in;
   entry_type        o_bid_ff, o_bid_in, o_ask_ff, o_ask_in;
   logic             o_bidv_ff, o_bidv_in, o_askv_ff, o_askv_in, o_last_ff, o_last_in;

   logic             we_bid, we_ask;
   logic [AW-1:0]    wr_addr, rd_addr;
   entry_type        wr_data, bid_rd, ask_rd, side_rd;
   logic [CW-1:0]    side_cnt, max_cnt;
   logic             out_free, bad, stay;
   logic [31:0]      sum;
   logic [VAL_W-1:0] sat_q;

   plob_ram #(.WIDTH($bits(entry_type)), .DEPTH(DEPTH)) u_bid_ram (
      .clock(clock), .wr_en(we_bid), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(bid_rd));
   plob_ram #(.WIDTH($bits(entry_type)), .DEPTH(DEPTH)) u_ask_ram (
      .clock(clock), .wr_en(we_ask), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(ask_rd));

   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign side_rd = side_ff ? ask_rd : bid_rd;
   assign side_cnt = side_ff ? ask_cnt_ff : bid_cnt_ff;
   assign max_cnt = (bid_cnt_ff > ask_cnt_ff) ? bid_cnt_ff : ask_cnt_ff;
   assign bad = (req_chan.price <= 0) || (req_chan.quantity <= 0);
   // asks stay ahead of equal prices, bids do not
   assign stay = side_ff ? (side_rd.price <= new_ff.price) : (side_rd.price > new_ff.price);
   assign sum = {1'b0, last_ff.qty} + {1'b0, side_rd.qty};
   assign sat_q = sum[31] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
   // the insert walk reads the entry just below idx; other walks read idx
   assign rd_addr = (state_ff == S_ADD_RD || state_ff == S_ADD_WR) ?
                    AW'(idx_ff - CW'(1)) : idx_ff[AW-1:0];

   // command sequencer
   always_comb begin
      state_in = state_ff;
      bid_cnt_in = bid_cnt_ff;
      ask_cnt_in = ask_cnt_ff;
      idx_in = idx_ff;
      wptr_in = wptr_ff;
      rows_in = rows_ff;
      side_in = side_ff;
      new_in = new_ff;
      last_in = last_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      o_status_in = o_status_ff;
      o_bid_in = o_bid_ff;
      o_ask_in = o_ask_ff;
      o_bidv_in = o_bidv_ff;
      o_askv_in = o_askv_ff;
      o_last_in = o_last_ff;
      we_bid = 1'b0;
      we_ask = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = new_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               side_in = req_chan.func[0];
               new_in.price = req_chan.price[VAL_W-1:0];
               new_in.qty = req_chan.quantity[VAL_W-1:0];
               status_in = STATUS_OK;
               idx_in = '0;
               wptr_in = '0;
               case (req_chan.func)
                  FUNC_ADD_BID, FUNC_ADD_ASK: begin
                     idx_in = req_chan.func[0] ? ask_cnt_ff : bid_cnt_ff;
                     if (bad) begin
                        status_in = STATUS_INVALID;
                        state_in = S_RESP;
                     end else if (idx_in == CW'(DEPTH)) begin
                        status_in = STATUS_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_ADD_RD;
                     end
                  end
                  FUNC_AGGREGATE: begin
                     side_in = 1'b0;
                     state_in = S_AGG_RD;
                  end
                  default: begin
                     rows_in = (32'(max_cnt) > 32'(MAX_ROWS)) ? CW'(MAX_ROWS) : max_cnt;
                     state_in = (max_cnt == '0) ? S_IDLE : S_DMP_RD;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            if (idx_ff == '0) begin
               we_bid = !side_ff;
               we_ask = side_ff;
               if (side_ff) ask_cnt_in = ask_cnt_ff + CW'(1);
               else bid_cnt_in = bid_cnt_ff + CW'(1);
               state_in = S_RESP;
            end else begin
               state_in = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            we_bid = !side_ff;
            we_ask = side_ff;
            if (stay) begin
               if (side_ff) ask_cnt_in = ask_cnt_ff + CW'(1);
               else bid_cnt_in = bid_cnt_ff + CW'(1);
               state_in = S_RESP;
            end else begin
               wr_data = side_rd;
               idx_in = idx_ff - CW'(1);
               state_in = S_ADD_RD;
            end
         end
         S_AGG_RD: begin
            if (idx_ff == side_cnt) begin
               if (side_ff) begin
                  ask_cnt_in = wptr_ff;
                  state_in = S_RESP;
               end else begin
                  bid_cnt_in = wptr_ff;
                  side_in = 1'b1;
                  idx_in = '0;
                  wptr_in = '0;
               end
            end else begin
               state_in = S_AGG_WR;
            end
         end
         S_AGG_WR: begin
            we_bid = !side_ff;
            we_ask = side_ff;
            if (wptr_ff != '0 && last_ff.price == side_rd.price) begin
               // merge into the last written entry
               wr_addr = AW'(wptr_ff - CW'(1));
               wr_data.price = last_ff.price;
               wr_data.qty = sat_q;
               last_in.qty = sat_q;
            end else begin
               wr_addr = wptr_ff[AW-1:0];
               wr_data = side_rd;
               last_in = side_rd;
               wptr_in = wptr_ff + CW'(1);
            end
            idx_in = idx_ff + CW'(1);
            state_in = S_AGG_RD;
         end
         S_DMP_RD: state_in = S_DMP_WR;
         S_DMP_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_status_in = STATUS_OK;
               o_bidv_in = idx_ff < bid_cnt_ff;
               o_askv_in = idx_ff < ask_cnt_ff;
               o_bid_in = o_bidv_in ? bid_rd : '0;
               o_ask_in = o_askv_in ? ask_rd : '0;
               o_last_in = (idx_ff + CW'(1)) == rows_ff;
               idx_in = idx_ff + CW'(1);
               state_in = o_last_in ? S_IDLE : S_DMP_RD;
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_status_in = status_ff;
               o_bid_in = '0;
               o_ask_in = '0;
               o_bidv_in = 1'b0;
               o_askv_in = 1'b0;
               o_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bid_cnt_ff <= '0;
         ask_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bid_cnt_ff <= bid_cnt_in;
         ask_cnt_ff <= ask_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      wptr_ff <= wptr_in;
      rows_ff <= rows_in;
      side_ff <= side_in;
      new_ff <= new_in;
      last_ff <= last_in;
      status_ff <= status_in;
      o_status_ff <= o_status_in;
      o_bid_ff <= o_bid_in;
      o_ask_ff <= o_ask_in;
      o_bidv_ff <= o_bidv_in;
      o_askv_ff <= o_askv_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = o_status_ff;
   assign rsp_chan.bid_price = o_bid_ff.price;
   assign rsp_chan.bid_qty = o_bid_ff.qty;
   assign rsp_chan.bid_valid = o_bidv_ff;
   assign rsp_chan.ask_price = o_ask_ff.price;
   assign rsp_chan.ask_qty = o_ask_ff.qty;
   assign rsp_chan.ask_valid = o_askv_ff;
   assign rsp_chan.last = o_last_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(bid_cnt_ff) <= DEPTH) && (32'(ask_cnt_ff) <= DEPTH))
      else $error("side count above depth");
   a_one_side_write: assert property (@(posedge clock) disable iff (reset)
      !(we_bid && we_ask))
      else $error("both side RAMs written at once");
   a_bad_add_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.func[1] && bad) |=>
      ($stable(bid_cnt_ff) && $stable(ask_cnt_ff)))
      else $error("invalid add changed the book");
   a_dump_row_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DMP_WR) |-> (idx_ff < rows_ff))
      else $error("dump row beyond row count");
`endif
endmodule
`default_nettype wire

@@ tb/tb_price_level_order_book.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_price_level_order_book;
   import plob_pkg::*;

   localparam int BOOK_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] price;
      logic [31:0] quantity;
   } order_cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [30:0] bid_price;
      logic [30:0] bid_qty;
      logic        bid_valid;
      logic [30:0] ask_price;
      logic [30:0] ask_qty;
      logic        ask_valid;
      logic        last;
   } book_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plob_req_if req_chan ();
   plob_rsp_if rsp_chan ();

   price_level_order_book #(.DEPTH(BOOK_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow book, best first on each side
   logic [30:0] bid_px [$];
   logic [30:0] bid_qt [$];
   logic [30:0] ask_px [$];
   logic [30:0] ask_qt [$];

   order_cmd_type pending_cmds [$];
   book_row_type  expected_rows [$];
   int errors = 0;
   int rows_seen = 0;
   int dumps_sent = 0;
   int full_hits = 0;
   int cycles = 0;
   bit hold_sender = 1'b0;
   bit req_taken = 1'b0;

   function automatic logic [30:0] sat_sum(logic [30:0] a, logic [30:0] b);
      logic [31:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[31] ? 31'h7FFF_FFFF : s[30:0];
   endfunction

   // merge runs of equal price on one side
   task automatic merge_levels(ref logic [30:0] px [$], ref logic [30:0] qt [$]);
      logic [30:0] np [$];
      logic [30:0] nq [$];
      for (int r = 0; r < px.size(); r++) begin
         if (np.size() > 0 && np[$] == px[r]) begin
            nq[$] = sat_sum(nq[$], qt[r]);
         end else begin
            np.push_back(px[r]);
            nq.push_back(qt[r]);
         end
      end
      px = np;
      qt = nq;
   endtask

   // compute the rows a command gives and update the shadow book
   task automatic predict_book(order_cmd_type c);
      book_row_type row;
      int pos;
      int n;
      row = '{default: '0};
      row.last = 1'b1;
      if (c.func == FUNC_ADD_BID || c.func == FUNC_ADD_ASK) begin
         if (c.price == 0 || c.price[31] || c.quantity == 0 || c.quantity[31]) begin
            row.status = STATUS_INVALID;
         end else if (c.func == FUNC_ADD_BID) begin
            if (bid_px.size() >= BOOK_DEPTH) begin
               row.status = STATUS_FULL;
               full_hits++;
            end else begin
               pos = 0;
               while (pos < bid_px.size() && bid_px[pos] > c.price[30:0]) pos++;
               bid_px.insert(pos, c.price[30:0]);
               bid_qt.insert(pos, c.quantity[30:0]);
            end
         end else begin
            if (ask_px.size() >= BOOK_DEPTH) begin
               row.status = STATUS_FULL;
               full_hits++;
            end else begin
               pos = 0;
               while (pos < ask_px.size() && ask_px[pos] <= c.price[30:0]) pos++;
               ask_px.insert(pos, c.price[30:0]);
               ask_qt.insert(pos, c.quantity[30:0]);
            end
         end
         expected_rows.push_back(row);
      end else if (c.func == FUNC_AGGREGATE) begin
         merge_levels(bid_px, bid_qt);
         merge_levels(ask_px, ask_qt);
         expected_rows.push_back(row);
      end else begin
         n = (bid_px.size() > ask_px.size()) ? bid_px.size() : ask_px.size();
         if (n > MAX_ROWS) n = MAX_ROWS;
         for (int i = 0; i < n; i++) begin
            row = '{default: '0};
            if (i < bid_px.size()) begin
               row.bid_price = bid_px[i];
               row.bid_qty = bid_qt[i];
               row.bid_valid = 1'b1;
            end
            if (i < ask_px.size()) begin
               row.ask_price = ask_px[i];
               row.ask_qty = ask_qt[i];
               row.ask_valid = 1'b1;
            end
            row.last = (i == n - 1);
            expected_rows.push_back(row);
         end
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // command beat taken at this rising edge: predict its results now
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         predict_book('{req_chan.func, req_chan.price, req_chan.quantity});
         req_taken = 1'b1;
      end
   end

   // driver: one command beat at a time, random gaps
   int drive_gap = 0;
   initial begin
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_ADD_BID;
      req_chan.price = '0;
      req_chan.quantity = '0;
   end
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_chan.valid <= 1'b0;
            drive_gap = gap_len();
         end else if (!req_chan.valid) begin
            if (drive_gap > 0) begin
               drive_gap--;
            end else if (!hold_sender && pending_cmds.size() > 0) begin
               order_cmd_type c;
               c = pending_cmds.pop_front();
               req_chan.func <= c.func;
               req_chan.price <= c.price;
               req_chan.quantity <= c.quantity;
               req_chan.valid <= 1'b1;
            end
         end
      end
   end

   // receiver stalls
   int stall_left = 0;
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_left = gap_len();
         rsp_chan.ready <= (stall_left == 0);
      end
   end

   // monitor: check each result beat against the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         book_row_type got;
         book_row_type exp_row;
         got = '{rsp_chan.status, rsp_chan.bid_price, rsp_chan.bid_qty, rsp_chan.bid_valid,
                 rsp_chan.ask_price, rsp_chan.ask_qty, rsp_chan.ask_valid, rsp_chan.last};
         rows_seen++;
         if (expected_rows.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %p", $realtime, got);
         end else begin
            exp_row = expected_rows.pop_front();
            if (got !== exp_row) begin
               errors++;
               $display("%0t: mismatch expected %p actual %p", $realtime, exp_row, got);
            end
         end
      end
   end

   function automatic order_cmd_type mk(logic [1:0] f, logic [31:0] p, logic [31:0] q);
      order_cmd_type c;
      c.func = f;
      c.price = p;
      c.quantity = q;
      return c;
   endfunction

   // mostly small positive values with repeats, sometimes any 32-bit value
   function automatic logic [31:0] rand_field(bit wide);
      int r;
      r = $urandom_range(0, 99);
      if (wide && r < 6) return $urandom();
      if (r < 10) return $urandom_range(1, 32'h7FFF_FFFF);
      if (r < 14) return 32'h7FFF_FFFF - $urandom_range(0, 3);
      return $urandom_range(1, 40);
   endfunction

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_chan.valid || expected_rows.size() > 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      int total;
      int r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty dump, invalid inputs, extremes, ties, overflow
      pending_cmds.push_back(mk(FUNC_DUMP, 0, 0));
      pending_cmds.push_back(mk(FUNC_ADD_BID, 0, 5));
      pending_cmds.push_back(mk(FUNC_ADD_ASK, 5, 0));
      pending_cmds.push_back(mk(FUNC_ADD_BID, 32'h8000_0000, 5));
      pending_cmds.push_back(mk(FUNC_ADD_ASK, 5, 32'hFFFF_FFFF));
      pending_cmds.push_back(mk(FUNC_ADD_BID, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_cmds.push_back(mk(FUNC_ADD_BID, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_cmds.push_back(mk(FUNC_ADD_BID, 1, 1));
      pending_cmds.push_back(mk(FUNC_ADD_BID, 100, 7));
      pending_cmds.push_back(mk(FUNC_ADD_BID, 100, 9));
      pending_cmds.push_back(mk(FUNC_ADD_ASK, 100, 3));
      pending_cmds.push_back(mk(FUNC_ADD_ASK, 100, 4));
      pending_cmds.push_back(mk(FUNC_ADD_ASK, 1, 32'h7FFF_FFFF));
      pending_cmds.push_back(mk(FUNC_ADD_ASK, 32'h7FFF_FFFF, 1));
      pending_cmds.push_back(mk(FUNC_ADD_ASK, 50, 32'h5555_5555));
      pending_cmds.push_back(mk(FUNC_ADD_ASK, 50, 32'h2AAA_AAAA));
      pending_cmds.push_back(mk(FUNC_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_cmds.push_back(mk(FUNC_AGGREGATE, 32'h8000_0000, 0));
      pending_cmds.push_back(mk(FUNC_DUMP, 0, 0));
      wait_drained();

      // hold the sender with a command queued, then release it and drain
      hold_sender = 1'b1;
      pending_cmds.push_back(mk(FUNC_ADD_BID, 3, 3));
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;
      wait_drained();

      // fill the bid side past full, then dump, aggregate and dump again
      for (int i = 0; i < BOOK_DEPTH; i++)
         pending_cmds.push_back(mk(FUNC_ADD_BID, $urandom_range(1, 20), rand_field(0)));
      pending_cmds.push_back(mk(FUNC_DUMP, 0, 0));
      pending_cmds.push_back(mk(FUNC_AGGREGATE, 0, 0));
      pending_cmds.push_back(mk(FUNC_DUMP, 0, 0));
      wait_drained();

      // random: mostly well-formed adds, with aggregates and dumps
      total = 0;
      while (total < 180) begin
         r = $urandom_range(0, 99);
         if (r < 42)
            pending_cmds.push_back(mk(FUNC_ADD_BID, rand_field(1), rand_field(1)));
         else if (r < 84)
            pending_cmds.push_back(mk(FUNC_ADD_ASK, rand_field(1), rand_field(1)));
         else if (r < 92)
            pending_cmds.push_back(mk(FUNC_AGGREGATE, $urandom(), $urandom()));
         else
            pending_cmds.push_back(mk(FUNC_DUMP, $urandom(), $urandom()));
         if (pending_cmds[$].func == FUNC_DUMP) dumps_sent++;
         total++;
      end
      pending_cmds.push_back(mk(FUNC_DUMP, 0, 0));
      wait_drained();
      repeat (300) @(posedge clock);

      $display("Covered adds with invalid, tied, extreme and full cases, aggregates, dumps;");
      $display("  %0d result beats checked, %0d full rejects, %0d random dumps, %0d errors",
               rows_seen, full_hits, dumps_sent, errors);
      if (errors == 0) begin
         $display("tb_price_level_order_book: PASS");
      end else begin
         $display("tb_price_level_order_book: FAIL");
      end
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_price_level_order_book: FAIL");
         $finish;
      end
   end
endmodule
`default_nettype wire

@@ files.f @@
src/plob_pkg.sv
src/plob_if.sv
src/plob_ram.sv
src/price_level_order_book.sv
tb/tb_price_level_order_book.sv
